@@ design/sfke_pkg.sv @@
package sfke_pkg;

  localparam int PAYLOAD_BYTES = 26;
  localparam int HEADER_BYTES  = 8;
  localparam int WIN_W         = HEADER_BYTES * 8;
  localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

  // fixed payload layout
  localparam int PITCH_AT = 4;
  localparam int ROLL_AT  = 8;
  localparam int FING0_AT = 24;
  localparam int FING1_AT = 25;

  localparam logic [WIN_W-1:0] DATA_HDR = 64'h9426ae784df69505;
  localparam logic [WIN_W-1:0] OFF_HDR  = 64'h9527af794ef79606;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  localparam int KEY_COUNT  = 9;
  localparam int PAY_EVENTS = 6;
  localparam int EV_W       = $clog2(PAY_EVENTS);

  localparam logic [3:0] KEY_FWD   = 4'd0;
  localparam logic [3:0] KEY_BACK  = 4'd1;
  localparam logic [3:0] KEY_TURNL = 4'd2;
  localparam logic [3:0] KEY_TURNR = 4'd3;
  localparam logic [3:0] KEY_FIRE  = 4'd6;
  localparam logic [3:0] KEY_USE   = 4'd7;
  localparam logic [3:0] KEY_LAST  = 4'(KEY_COUNT - 1);

  // payload event order
  localparam logic [3:0] EV_KEY [PAY_EVENTS] = '{
    KEY_TURNL, KEY_TURNR, KEY_BACK, KEY_FWD, KEY_FIRE, KEY_USE
  };

  localparam logic [2:0] CFG_ROLL_LEFT  = 3'd0;
  localparam logic [2:0] CFG_ROLL_RIGHT = 3'd1;
  localparam logic [2:0] CFG_PITCH_BACK = 3'd2;
  localparam logic [2:0] CFG_PITCH_FWD  = 3'd3;
  localparam logic [2:0] CFG_FIRE       = 3'd4;
  localparam logic [2:0] CFG_USE        = 3'd5;

  localparam logic [31:0] RST_ROLL_LEFT  = -32'sd10000;
  localparam logic [31:0] RST_ROLL_RIGHT = 32'd20000;
  localparam logic [31:0] RST_PITCH_BACK = 32'd10000;
  localparam logic [31:0] RST_PITCH_FWD  = -32'sd10000;
  localparam logic [7:0]  RST_FIRE       = 8'd70;
  localparam logic [7:0]  RST_USE        = 8'd60;

  typedef struct packed {
    logic        is_off;
    logic [31:0] pitch;
    logic [31:0] roll;
    logic [7:0]  fing0;
    logic [7:0]  fing1;
  } cmd_t;

  typedef struct packed {
    logic [31:0] roll_left;
    logic [31:0] roll_right;
    logic [31:0] pitch_back;
    logic [31:0] pitch_fwd;
    logic [7:0]  fire;
    logic [7:0]  use_lim;
  } limits_t;

  typedef struct packed {
    logic [3:0] key_index;
    logic       key_down;
    logic       last_event;
  } evt_t;

endpackage

@@ design/sfke_front.sv @@
module sfke_front
  import sfke_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_rx_byte,
  input  logic       q_full,
  output logic       cmd_push,
  output cmd_t       cmd_data
);

  logic [WIN_W-1:0] win_r, win_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      pitch_r, pitch_nxt;
  logic [31:0]      roll_r, roll_nxt;
  logic [7:0]       fing0_r, fing0_nxt;
  logic [7:0]       fing1_r, fing1_nxt;
  logic [CNT_W-1:0] pos;
  logic [IDX_W-1:0] idx;
  logic             accept;

  always_comb begin
    accept    = in_push && !q_full;
    win_nxt   = win_r;
    cnt_nxt   = cnt_r;
    pitch_nxt = pitch_r;
    roll_nxt  = roll_r;
    fing0_nxt = fing0_r;
    fing1_nxt = fing1_r;
    cmd_push  = 1'b0;
    pos       = CNT_W'(PAYLOAD_BYTES) - cnt_r;
    idx       = pos[IDX_W-1:0];
    cmd_data.is_off = 1'b0;
    if (accept) begin
      if (cnt_r != '0) begin
        // payload byte, kept only where the layout needs it
        for (int k = 0; k < 4; k++) begin
          if (idx == IDX_W'(PITCH_AT + k)) pitch_nxt[8*k +: 8] = in_rx_byte;
          if (idx == IDX_W'(ROLL_AT + k))  roll_nxt[8*k +: 8]  = in_rx_byte;
        end
        if (idx == IDX_W'(FING0_AT)) fing0_nxt = in_rx_byte;
        if (idx == IDX_W'(FING1_AT)) fing1_nxt = in_rx_byte;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) cmd_push = 1'b1;
      end else begin
        win_nxt = {win_r[WIN_W-9:0], in_rx_byte};
        priority if (win_nxt == DATA_HDR) begin
          cnt_nxt = CNT_W'(PAYLOAD_BYTES);
        end else if (win_nxt == OFF_HDR) begin
          cmd_push        = 1'b1;
          cmd_data.is_off = 1'b1;
        end
      end
    end
    cmd_data.pitch = pitch_nxt;
    cmd_data.roll  = roll_nxt;
    cmd_data.fing0 = fing0_nxt;
    cmd_data.fing1 = fing1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      cnt_r <= '0;
    end else begin
      win_r <= win_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pitch_r <= pitch_nxt;
    roll_r  <= roll_nxt;
    fing0_r <= fing0_nxt;
    fing1_r <= fing1_nxt;
  end

endmodule

@@ design/sfke_cmdq.sv @@
module sfke_cmdq
  import sfke_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t               mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CMDQ_CW-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  always_comb begin
    full     = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
    empty    = (cnt_r == '0);
    do_push  = push && !full;
    do_pop   = pop && !empty;
    pop_data = mem[rp_r];
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    if (do_push) wp_nxt = (wp_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_pop)  rp_nxt = (rp_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r + CMDQ_CW'(do_push) - CMDQ_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= push_data;
  end

endmodule

@@ design/sfke_back.sv @@
module sfke_back
  import sfke_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_empty,
  input  cmd_t       cmd_data,
  output logic       cmd_pop,
  input  limits_t    lim,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [3:0] out_key_index,
  output logic       out_key_down,
  output logic       out_last_event
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PAY  = 3'b010,
    ST_OFF  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [KEY_COUNT-1:0]   key_r, key_nxt;
  logic [PAY_EVENTS-1:0]  pend_r, pend_nxt;
  logic [PAY_EVENTS-1:0]  want_r, want_nxt;
  logic [3:0]             offk_r, offk_nxt;
  logic [PAY_EVENTS-1:0]  want, cur, rest;
  logic [EV_W-1:0]        first;
  logic                   found;
  logic                   room;
  logic                   ev_valid;
  evt_t                   ev;

  evt_t                   oq [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [OUTQ_CW-1:0]     oc_r, oc_nxt;
  logic                   do_out;

  always_comb begin
    want[0] = $signed(cmd_data.roll)  < $signed(lim.roll_left);
    want[1] = $signed(cmd_data.roll)  > $signed(lim.roll_right);
    want[2] = $signed(cmd_data.pitch) > $signed(lim.pitch_back);
    want[3] = $signed(cmd_data.pitch) < $signed(lim.pitch_fwd);
    want[4] = $signed(cmd_data.fing1) > $signed(lim.fire);
    want[5] = $signed(cmd_data.fing0) > $signed(lim.use_lim);
    for (int i = 0; i < PAY_EVENTS; i++) cur[i] = key_r[EV_KEY[i]];

    first = '0;
    found = 1'b0;
    for (int i = 0; i < PAY_EVENTS; i++) begin
      if (pend_r[i] && !found) begin
        first = EV_W'(i);
        found = 1'b1;
      end
    end
    rest = pend_r & ~(PAY_EVENTS'(1) << first);
  end

  always_comb begin
    room      = (oc_r != OUTQ_CW'(OUTQ_DEPTH));
    cmd_pop   = (state_r == ST_IDLE) && !cmd_empty;
    state_nxt = state_r;
    key_nxt   = key_r;
    pend_nxt  = pend_r;
    want_nxt  = want_r;
    offk_nxt  = offk_r;
    ev_valid  = 1'b0;
    ev        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          if (cmd_data.is_off) begin
            state_nxt = ST_OFF;
            offk_nxt  = KEY_LAST;
            key_nxt   = '0;
          end else begin
            // key state moves at load; events drain afterwards
            for (int i = 0; i < PAY_EVENTS; i++) key_nxt[EV_KEY[i]] = want[i];
            pend_nxt = want ^ cur;
            want_nxt = want;
            if ((want ^ cur) != '0) state_nxt = ST_PAY;
          end
        end
      end
      ST_PAY: begin
        if (room) begin
          ev_valid      = 1'b1;
          ev.key_index  = EV_KEY[first];
          ev.key_down   = want_r[first];
          ev.last_event = (rest == '0);
          pend_nxt      = rest;
          if (rest == '0) state_nxt = ST_IDLE;
        end
      end
      ST_OFF: begin
        if (room) begin
          ev_valid      = 1'b1;
          ev.key_index  = offk_r;
          ev.key_down   = 1'b0;
          ev.last_event = (offk_r == '0);
          offk_nxt      = offk_r - 1'b1;
          if (offk_r == '0) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result queue
  always_comb begin
    out_empty      = (oc_r == '0);
    do_out         = out_pop && !out_empty;
    out_key_index  = oq[rp_r].key_index;
    out_key_down   = oq[rp_r].key_down;
    out_last_event = oq[rp_r].last_event;
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (ev_valid) wp_nxt = (wp_r == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_out)   rp_nxt = (rp_r == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    oc_nxt = oc_r + OUTQ_CW'(ev_valid) - OUTQ_CW'(do_out);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      key_r   <= '0;
      pend_r  <= '0;
      offk_r  <= '0;
      wp_r    <= '0;
      rp_r    <= '0;
      oc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
      pend_r  <= pend_nxt;
      offk_r  <= offk_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      oc_r    <= oc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    want_r <= want_nxt;
    if (ev_valid) oq[wp_r] <= ev;
  end

endmodule

@@ design/sensor_frame_to_key_events.sv @@
// channel  | ports                                        | transfer when
// ---------+----------------------------------------------+---------------------
// input    | in_push, in_full, in_rx_byte                 | in_push && !in_full
// result   | out_empty, out_pop, out_key_index,           | out_pop && !out_empty
//          | out_key_down, out_last_event                 |
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data    | cfg_valid && cfg_ready
//
// the front takes one byte per cycle while the command queue is not full; a byte
// that ends a payload or an off header queues one command for the back
// the back drains commands one event per cycle while the result queue has room:
// up to 6 events per payload, 9 per off header, after each command loads in idle
// in_full rises only while the 2-entry command queue is full; pop stalls fill the
// 2-entry result queue and hold the back, then reach in_full once commands back up
// reset is synchronous; cfg_ready is always high
module sensor_frame_to_key_events
  import sfke_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_key_index,
  output logic        out_key_down,
  output logic        out_last_event,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  limits_t lim_r, lim_nxt;
  logic    cmd_push, cmd_pop, cmd_empty, cmd_full;
  cmd_t    cmd_in, cmd_out;

  assign cfg_ready = 1'b1;
  assign in_full   = cmd_full;

  always_comb begin
    lim_nxt = lim_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROLL_LEFT:  lim_nxt.roll_left  = cfg_data;
        CFG_ROLL_RIGHT: lim_nxt.roll_right = cfg_data;
        CFG_PITCH_BACK: lim_nxt.pitch_back = cfg_data;
        CFG_PITCH_FWD:  lim_nxt.pitch_fwd  = cfg_data;
        CFG_FIRE:       lim_nxt.fire       = cfg_data[7:0];
        CFG_USE:        lim_nxt.use_lim    = cfg_data[7:0];
        default:        lim_nxt = lim_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.roll_left  <= RST_ROLL_LEFT;
      lim_r.roll_right <= RST_ROLL_RIGHT;
      lim_r.pitch_back <= RST_PITCH_BACK;
      lim_r.pitch_fwd  <= RST_PITCH_FWD;
      lim_r.fire       <= RST_FIRE;
      lim_r.use_lim    <= RST_USE;
    end else begin
      lim_r <= lim_nxt;
    end
  end

  sfke_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .q_full     (cmd_full),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_in)
  );

  sfke_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  sfke_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_empty      (cmd_empty),
    .cmd_data       (cmd_out),
    .cmd_pop        (cmd_pop),
    .lim            (lim_r),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_key_index  (out_key_index),
    .out_key_down   (out_key_down),
    .out_last_event (out_last_event)
  );

endmodule

@@ design/sfke_chk.sv @@
module sfke_chk
  import sfke_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic [7:0]  in_rx_byte,
  input logic        out_empty,
  input logic        out_pop,
  input logic [3:0]  out_key_index,
  input logic        out_key_down,
  input logic        out_last_event,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [31:0] cfg_data
);

  // both queues come out of reset empty
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_key_index <= KEY_LAST)
    else $error("key index out of range");

  // strafe and next weapon keys are only ever released
  a_press_keys: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_key_down |->
      out_key_index == KEY_FWD || out_key_index == KEY_BACK ||
      out_key_index == KEY_TURNL || out_key_index == KEY_TURNR ||
      out_key_index == KEY_FIRE || out_key_index == KEY_USE)
    else $error("press on a key that is never pressed");

  // the highest key only opens an off-header group
  a_off_first: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_key_index == KEY_LAST |-> !out_key_down && !out_last_event)
    else $error("unexpected release order");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_key_index) &&
      $stable(out_key_down) && $stable(out_last_event))
    else $error("waiting result changed");

endmodule

bind sensor_frame_to_key_events sfke_chk u_sfke_chk (.*);

@@ test/key_event_checker.sv @@
module key_event_checker
  import sfke_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [3:0]  out_key_index,
  input  logic        out_key_down,
  input  logic        out_last_event,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          due_count,
  output int          made_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] roll_left_lim, roll_right_lim, pitch_back_lim, pitch_fwd_lim;
  logic signed [7:0]  fire_lim, use_lim;

  logic [WIN_W-1:0]   window;
  int                 bytes_left;
  logic [7:0]         frame_buf [PAYLOAD_BYTES];
  logic [KEY_COUNT-1:0] held;

  evt_t key_events_due [$];

  initial begin
    fail_count = 0;
    due_count  = 0;
    made_count = 0;
  end

  task automatic add_event(input logic [3:0] key, input logic down, input logic last);
    evt_t ev;
    ev.key_index  = key;
    ev.key_down   = down;
    ev.last_event = last;
    key_events_due.push_back(ev);
    made_count++;
  endtask

  task automatic set_key(input logic [3:0] key, input logic want);
    if (held[key] != want) begin
      held[key] = want;
      add_event(key, want, 1'b0);
    end
  endtask

  task automatic apply_payload();
    logic signed [31:0] pitch, roll;
    logic signed [7:0]  fing0, fing1;
    int                 n_before;
    pitch = {frame_buf[PITCH_AT+3], frame_buf[PITCH_AT+2],
             frame_buf[PITCH_AT+1], frame_buf[PITCH_AT]};
    roll  = {frame_buf[ROLL_AT+3], frame_buf[ROLL_AT+2],
             frame_buf[ROLL_AT+1], frame_buf[ROLL_AT]};
    fing0 = frame_buf[FING0_AT];
    fing1 = frame_buf[FING1_AT];
    n_before = key_events_due.size();
    set_key(KEY_TURNL, roll < roll_left_lim);
    set_key(KEY_TURNR, roll > roll_right_lim);
    set_key(KEY_BACK, pitch > pitch_back_lim);
    set_key(KEY_FWD, pitch < pitch_fwd_lim);
    set_key(KEY_FIRE, fing1 > fire_lim);
    set_key(KEY_USE, fing0 > use_lim);
    if (key_events_due.size() > n_before) begin
      key_events_due[key_events_due.size()-1].last_event = 1'b1;
    end
  endtask

  task automatic predict_byte(input logic [7:0] b);
    if (bytes_left != 0) begin
      // payload bytes bypass the header window
      frame_buf[PAYLOAD_BYTES - bytes_left] = b;
      bytes_left--;
      if (bytes_left == 0) apply_payload();
    end else begin
      window = {window[WIN_W-9:0], b};
      if (window == DATA_HDR) begin
        bytes_left = PAYLOAD_BYTES;
      end else if (window == OFF_HDR) begin
        for (int k = KEY_COUNT - 1; k >= 0; k--) begin
          add_event(4'(k), 1'b0, k == 0);
        end
        held = '0;
      end
    end
  endtask

  always @(posedge clk) begin
    evt_t want_ev;
    if (!rst_n) begin
      roll_left_lim  = RST_ROLL_LEFT;
      roll_right_lim = RST_ROLL_RIGHT;
      pitch_back_lim = RST_PITCH_BACK;
      pitch_fwd_lim  = RST_PITCH_FWD;
      fire_lim       = RST_FIRE;
      use_lim        = RST_USE;
      window         = '0;
      bytes_left     = 0;
      held           = '0;
      key_events_due.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (key_events_due.size() == 0) begin
          $display("%0t: key event with none due: expected nothing, got index %0d down %0b last %0b",
                   $time, out_key_index, out_key_down, out_last_event);
          fail_count++;
        end else begin
          want_ev = key_events_due.pop_front();
          if (out_key_index !== want_ev.key_index) begin
            $display("%0t: key_index expected %0d got %0d", $time, want_ev.key_index,
                     out_key_index);
            fail_count++;
          end
          if (out_key_down !== want_ev.key_down) begin
            $display("%0t: key_down expected %0b got %0b", $time, want_ev.key_down,
                     out_key_down);
            fail_count++;
          end
          if (out_last_event !== want_ev.last_event) begin
            $display("%0t: last_event expected %0b got %0b", $time, want_ev.last_event,
                     out_last_event);
            fail_count++;
          end
        end
      end
      if (in_push && !in_full) predict_byte(in_rx_byte);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROLL_LEFT:  roll_left_lim  = cfg_data;
          CFG_ROLL_RIGHT: roll_right_lim = cfg_data;
          CFG_PITCH_BACK: pitch_back_lim = cfg_data;
          CFG_PITCH_FWD:  pitch_fwd_lim  = cfg_data;
          CFG_FIRE:       fire_lim       = cfg_data[7:0];
          CFG_USE:        use_lim        = cfg_data[7:0];
          default: ;
        endcase
      end
    end
    due_count = key_events_due.size();
  end

endmodule

@@ test/tb_top.sv @@
module tb_top;
  import sfke_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_BYTES   = 20;
  localparam int PHASE_EVENTS  = 9;
  localparam int PHASE_FRAMES  = 2;

  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [7:0]  S8_MIN  = 8'h80;
  localparam logic [7:0]  S8_MAX  = 8'h7f;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_rx_byte = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [3:0]  out_key_index;
  logic        out_key_down;
  logic        out_last_event;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int fail_count, due_count, made_count;
  int cycles = 0;
  int bytes_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  logic [31:0] cur_rl, cur_rr, cur_pb, cur_pf;
  logic [7:0]  cur_fire, cur_use;

  sensor_frame_to_key_events dut (.*);

  key_event_checker checker_i (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver side, with a long hold-off when asked for
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_header(input logic [WIN_W-1:0] hdr);
    for (int i = HEADER_BYTES - 1; i >= 0; i--) send_byte(hdr[i*8 +: 8]);
  endtask

  task automatic send_data_frame(input logic [31:0] pitch, input logic [31:0] roll,
                                 input logic [7:0] fing0, input logic [7:0] fing1,
                                 input logic embed_hdrs);
    logic [7:0] pay [PAYLOAD_BYTES];
    for (int i = 0; i < PAYLOAD_BYTES; i++) pay[i] = 8'($urandom);
    for (int i = 0; i < 4; i++) begin
      pay[PITCH_AT+i] = pitch[i*8 +: 8];
      pay[ROLL_AT+i]  = roll[i*8 +: 8];
    end
    pay[FING0_AT] = fing0;
    pay[FING1_AT] = fing1;
    // an off header and a partial data header in spare bytes must not match
    if (embed_hdrs) begin
      for (int i = 0; i < HEADER_BYTES; i++) begin
        pay[12+i] = OFF_HDR[(HEADER_BYTES-1-i)*8 +: 8];
      end
      for (int i = 0; i < 4; i++) pay[20+i] = DATA_HDR[(HEADER_BYTES-1-i)*8 +: 8];
    end
    send_header(DATA_HDR);
    for (int i = 0; i < PAYLOAD_BYTES; i++) send_byte(pay[i]);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_limits(input logic [31:0] rl, input logic [31:0] rr,
                            input logic [31:0] pb, input logic [31:0] pf,
                            input logic [7:0] fire, input logic [7:0] use_v);
    logic [31:0] wide;
    cfg_write(CFG_ROLL_LEFT, rl);
    cfg_write(CFG_ROLL_RIGHT, rr);
    cfg_write(CFG_PITCH_BACK, pb);
    cfg_write(CFG_PITCH_FWD, pf);
    wide = $urandom;
    wide[7:0] = fire;
    cfg_write(CFG_FIRE, wide);
    wide = $urandom;
    wide[7:0] = use_v;
    cfg_write(CFG_USE, wide);
    // unused indexes must leave every limit alone
    cfg_write($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
    cfg_valid <= 1'b0;
    cur_rl = rl;
    cur_rr = rr;
    cur_pb = pb;
    cur_pf = pf;
    cur_fire = fire;
    cur_use = use_v;
  endtask

  task automatic wait_idle();
    while (due_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick32(input logic [31:0] lim_a, input logic [31:0] lim_b);
    case ($urandom_range(4))
      0: pick32 = $urandom;
      1: pick32 = lim_a + 32'($urandom_range(2)) - 32'd1;
      2: pick32 = lim_b + 32'($urandom_range(2)) - 32'd1;
      3: pick32 = $urandom_range(1) ? S32_MAX : S32_MIN;
      default: pick32 = lim_a + 32'($urandom_range(60000)) - 32'd30000;
    endcase
  endfunction

  function automatic logic [7:0] pick8(input logic [7:0] lim);
    case ($urandom_range(3))
      0: pick8 = 8'($urandom);
      1: pick8 = lim + 8'($urandom_range(2)) - 8'd1;
      2: pick8 = $urandom_range(1) ? S8_MAX : S8_MIN;
      default: pick8 = lim + 8'($urandom_range(40)) - 8'd20;
    endcase
  endfunction

  task automatic send_random_frame();
    logic [WIN_W-1:0] hdr;
    int               r, n;
    r = $urandom_range(99);
    if (r < 55) begin
      send_data_frame(pick32(cur_pb, cur_pf), pick32(cur_rl, cur_rr), pick8(cur_use),
                      pick8(cur_fire), $urandom_range(9) == 0);
    end else if (r < 75) begin
      send_header(OFF_HDR);
    end else if (r < 87) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end else begin
      // header cut short by one wrong byte
      hdr = $urandom_range(1) ? DATA_HDR : OFF_HDR;
      n = $urandom_range(1, 7);
      for (int i = HEADER_BYTES - 1; i >= HEADER_BYTES - n; i--) send_byte(hdr[i*8 +: 8]);
      send_byte(hdr[(HEADER_BYTES-1-n)*8 +: 8] ^ 8'($urandom_range(1, 255)));
    end
  endtask

  task automatic random_phase();
    int start_bytes, start_made, frames;
    start_bytes = bytes_sent;
    start_made  = made_count;
    frames = 0;
    while ((bytes_sent - start_bytes < PHASE_BYTES || made_count - start_made < PHASE_EVENTS)
           && frames < PHASE_FRAMES) begin
      send_random_frame();
      frames++;
    end
    in_push <= 1'b0;
    wait_idle();
  endtask

  initial begin
    cur_rl = RST_ROLL_LEFT;
    cur_rr = RST_ROLL_RIGHT;
    cur_pb = RST_PITCH_BACK;
    cur_pf = RST_PITCH_FWD;
    cur_fire = RST_FIRE;
    cur_use = RST_USE;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset limits, no idling
    send_header(OFF_HDR);
    send_data_frame(S32_MIN, S32_MIN, S8_MAX, S8_MAX, 1'b0);
    send_data_frame(S32_MAX, S32_MAX, S8_MIN, S8_MIN, 1'b0);
    send_data_frame(S32_MAX, S32_MAX, S8_MIN, S8_MIN, 1'b0);
    // exactly on the limits presses nothing
    send_data_frame(RST_PITCH_BACK, RST_ROLL_LEFT, RST_USE, RST_FIRE, 1'b0);
    send_data_frame(RST_PITCH_FWD - 32'd1, RST_ROLL_LEFT - 32'd1, RST_USE + 8'd1,
                    RST_FIRE + 8'd1, 1'b1);
    send_header(OFF_HDR);
    for (int i = HEADER_BYTES - 1; i >= 1; i--) send_byte(DATA_HDR[i*8 +: 8]);
    send_byte(8'h00);
    send_byte(8'hff);
    send_header(OFF_HDR);
    in_push <= 1'b0;
    wait_idle();

    // random limits, no idling, with a long receiver hold-off to fill the block
    set_limits($urandom, $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom));
    hold_reqs++;
    repeat (3) send_header(OFF_HDR);
    send_data_frame(pick32(cur_pb, cur_pf), pick32(cur_rl, cur_rr),
                    pick8(cur_use), pick8(cur_fire), 1'b0);
    in_push <= 1'b0;
    wait_idle();

    // everything pressed unless at the extreme, sender idling
    idle_pct = 74;
    set_limits(S32_MAX, S32_MIN, S32_MIN, S32_MAX, S8_MIN, S8_MIN);
    random_phase();

    // nothing ever pressed, receiver stalling
    idle_pct = 0;
    stall_pct = 74;
    set_limits(S32_MIN, S32_MAX, S32_MAX, S32_MIN, S8_MAX, S8_MAX);
    random_phase();

    // reset limits again, both sides idling
    idle_pct = 25;
    stall_pct = 25;
    set_limits(RST_ROLL_LEFT, RST_ROLL_RIGHT, RST_PITCH_BACK, RST_PITCH_FWD, RST_FIRE,
               RST_USE);
    random_phase();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
